// ----- rtl/core/dqd_pkg.sv -----
// Shared constants and the cosine table generator for the oscillator derivative.
// No dependencies.
package dqd_pkg;

    localparam int unsigned COS_TABLE_BITS_DEF = 10;

    localparam logic [31:0] ACQ_START_RST = 32'd655360;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic [63:0] TWO_PI_Q32 = 64'h6_487E_D511;

    // config register indexes
    localparam logic [1:0] CFG_DAMPING  = 2'd0;
    localparam logic [1:0] CFG_FORCE_A  = 2'd1;
    localparam logic [1:0] CFG_FORCE_W  = 2'd2;
    localparam logic [1:0] CFG_ACQ_START = 2'd3;

    // cos of m / 2^bits turns, m within the first quarter, Q2.30
    function automatic logic signed [31:0] cos_fn(input int unsigned m,
                                                 input int unsigned bits);
        logic [63:0] th;
        logic [63:0] t2;
        logic [63:0] term;
        logic signed [63:0] c;
        th = ((64'(m) * TWO_PI_Q32) + (64'd1 << (bits + 1))) >> (bits + 2);
        t2 = (th * th + (64'd1 << 29)) >> 30;
        term = 64'd1 << 30;
        c = signed'(term);
        for (int k = 1; k <= 9; k++) begin
            term = ((term * t2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if ((k & 1) == 1) begin
                c = c - signed'(term);
            end else begin
                c = c + signed'(term);
            end
        end
        return c[31:0];
    endfunction

endpackage

// ----- rtl/core/duffing_quartic_derivative.sv -----
// Top level: pipelined derivative of a forced oscillator with a quartic term.
// Depends on dqd_pkg.
//
// One item enters per cycle unless the pipeline is stalled; its result leaves
// through an eight-stage pipeline whose depth is set by the phase path (frequency
// times time, turn conversion, table lookup, amplitude multiply). A stall at the
// output while it holds a valid result freezes every stage. The cosine table has
// 2^(COS_TABLE_BITS-2)+1 entries of constant logic with a registered read.
module duffing_quartic_derivative
    import dqd_pkg::*;
#(
    parameter int unsigned COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_pos,
    input  logic signed [31:0] i_vel,
    input  logic [31:0]        i_sim_time,
    input  logic signed [31:0] i_drive,
    input  logic               i_hit,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [28:0] o_pos_rate,
    output logic signed [47:0] o_vel_rate,
    output logic [30:0]        o_phase_rate,
    output logic               o_capture
);

    localparam int unsigned N = COS_TABLE_BITS;
    localparam int unsigned QUARTER = 1 << (N - 2);
    localparam int unsigned DEPTH = 8;

    // config
    logic signed [31:0] r_damp;
    logic signed [31:0] r_amp;
    logic [30:0]        r_omega;
    logic [31:0]        r_acq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damp  <= '0;
            r_amp   <= '0;
            r_omega <= '0;
            r_acq   <= ACQ_START_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DAMPING:   r_damp  <= i_cfg_wdata;
                CFG_FORCE_A:   r_amp   <= i_cfg_wdata;
                CFG_FORCE_W:   r_omega <= i_cfg_wdata[30:0];
                CFG_ACQ_START: r_acq   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [DEPTH-1:0] r_vld;
    logic             en;

    assign en      = !r_vld[DEPTH-1] || !i_stall;
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    // constant cosine table
    logic signed [31:0] w_rom [0:QUARTER];
    for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
        assign w_rom[g] = cos_fn(g, N);
    end

    // stage 1: clamp, omega*t, capture compare
    logic signed [28:0] n_x, n_v;
    logic signed [28:0] r1_x, r1_v;
    logic signed [31:0] r1_drv;
    logic               r1_cap;
    logic [62:0]        r1_p;

    always_comb begin
        if (i_pos > 32'sd134217728)       n_x = 29'sd134217728;
        else if (i_pos < -32'sd134217728) n_x = -29'sd134217728;
        else                              n_x = i_pos[28:0];
        if (i_vel > 32'sd251658240)       n_v = 29'sd251658240;
        else if (i_vel < -32'sd251658240) n_v = -29'sd251658240;
        else                              n_v = i_vel[28:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x   <= n_x;
            r1_v   <= n_v;
            r1_drv <= i_drive;
            r1_cap <= i_hit && (i_sim_time >= r_acq);
            r1_p   <= 63'(r_omega) * 63'(i_sim_time);
        end
    end

    // stage 2: square, linear branch, damping product, turn products
    logic [27:0]        w2_ax;
    logic [55:0]        w2_sq;
    logic signed [35:0] w2_lin;
    logic signed [28:0] r2_x, r2_v;
    logic signed [31:0] r2_drv;
    logic               r2_cap;
    logic               r2_knee;
    logic [28:0]        r2_s;
    logic signed [35:0] r2_lin;
    logic signed [59:0] r2_dv;
    logic [60:0]        r2_a;
    logic [61:0]        r2_b;

    always_comb begin
        w2_ax  = r1_x[28] ? 28'(-r1_x) : 28'(r1_x);
        w2_sq  = 56'(w2_ax) * 56'(w2_ax) + 56'd8388608;
        w2_lin = 36'sh1_0000_0000 + (signed'({8'd0, w2_ax}) - 36'sd67108864) * 36'sd256;
        if (r1_x[28]) w2_lin = -w2_lin;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_x    <= r1_x;
            r2_v    <= r1_v;
            r2_drv  <= r1_drv;
            r2_cap  <= r1_cap;
            r2_knee <= w2_ax <= 28'd67108864;
            r2_s    <= w2_sq[52:24];
            r2_lin  <= w2_lin;
            r2_dv   <= 60'(r_damp) * 60'(r1_v);
            r2_a    <= 61'(r1_p[62:32]) * 61'(INV_TWO_PI_Q32);
            r2_b    <= 62'(r1_p[31:0]) * 62'(INV_TWO_PI_Q32);
        end
    end

    // stage 3: fourth power, damping term, phase in turns
    logic [57:0]        w3_q;
    logic signed [59:0] w3_dr;
    logic [60:0]        w3_ph;
    logic signed [28:0] r3_x, r3_v;
    logic signed [31:0] r3_drv;
    logic               r3_cap;
    logic signed [35:0] r3_quart;
    logic signed [35:0] r3_damp;
    logic [31:0]        r3_ph;

    always_comb begin
        w3_q  = 58'(r2_s) * 58'(r2_s) + 58'd8388608;
        w3_dr = r2_dv + 60'sd8388608;
        w3_ph = r2_a + 61'(r2_b[61:32]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_x     <= r2_x;
            r3_v     <= r2_v;
            r3_drv   <= r2_drv;
            r3_cap   <= r2_cap;
            r3_quart <= r2_knee ? signed'({3'd0, w3_q[56:24]}) : r2_lin;
            r3_damp  <= w3_dr[59:24];
            r3_ph    <= w3_ph[39:8];
        end
    end

    // stage 4: partial sum, table address and quadrant
    logic [32:0]        w4_rnd;
    logic [N-1:0]       w4_idx;
    logic [N-2:0]       w4_r;
    logic signed [28:0] r4_v;
    logic signed [31:0] r4_drv;
    logic               r4_cap;
    logic signed [47:0] r4_acc;
    logic [N-2:0]       r4_m;
    logic               r4_neg;

    always_comb begin
        w4_rnd = 33'(r3_ph) + (33'd1 << (31 - N));
        w4_idx = w4_rnd[31:32-N];
        w4_r   = (N-1)'(w4_idx[N-3:0]);
    end

    // odd quadrants fold the offset back from the quarter; the middle two negate
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_v   <= r3_v;
            r4_drv <= r3_drv;
            r4_cap <= r3_cap;
            r4_acc <= 48'(r3_x) - 48'(r3_quart) - 48'(r3_damp);
            r4_m   <= w4_idx[N-2] ? (N-1)'(QUARTER) - w4_r : w4_r;
            r4_neg <= w4_idx[N-1] ^ w4_idx[N-2];
        end
    end

    // stage 5: table read
    logic signed [28:0] r5_v;
    logic signed [31:0] r5_drv;
    logic               r5_cap;
    logic signed [47:0] r5_acc;
    logic signed [31:0] r5_c;
    logic               r5_neg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_v   <= r4_v;
            r5_drv <= r4_drv;
            r5_cap <= r4_cap;
            r5_acc <= r4_acc;
            r5_c   <= w_rom[r4_m];
            r5_neg <= r4_neg;
        end
    end

    // stage 6: quadrant sign, down to Q24
    logic signed [32:0] w6_c;
    logic signed [28:0] r6_v;
    logic signed [31:0] r6_drv;
    logic               r6_cap;
    logic signed [47:0] r6_acc;
    logic signed [25:0] r6_cos;

    always_comb begin
        w6_c = (r5_neg ? -33'(r5_c) : 33'(r5_c)) + 33'sd32;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_v   <= r5_v;
            r6_drv <= r5_drv;
            r6_cap <= r5_cap;
            r6_acc <= r5_acc;
            r6_cos <= w6_c[31:6];
        end
    end

    // stage 7: amplitude times cosine
    logic signed [28:0] r7_v;
    logic signed [31:0] r7_drv;
    logic               r7_cap;
    logic signed [47:0] r7_acc;
    logic signed [57:0] r7_fp;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_v   <= r6_v;
            r7_drv <= r6_drv;
            r7_cap <= r6_cap;
            r7_acc <= r6_acc;
            r7_fp  <= 58'(r_amp) * 58'(r6_cos);
        end
    end

    // stage 8: final sum into output register
    logic signed [57:0] w8_f;

    assign w8_f = r7_fp + 58'sd8388608;

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_pos_rate <= r7_v;
            o_vel_rate <= r7_acc + 48'(signed'(w8_f[57:24])) + 48'(r7_drv);
            o_capture  <= r7_cap;
        end
    end

    assign o_valid      = r_vld[DEPTH-1];
    assign o_phase_rate = r_omega;

endmodule

// ----- tb/duffing_quartic_derivative_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for duffing_quartic_derivative: directed table, then random items
// under several register settings, each result checked against a listed expectation or an in-bench predictor.
// Depends on dqd_pkg and the duffing_quartic_derivative RTL.
module duffing_quartic_derivative_tb;
    import dqd_pkg::*;

    localparam int TBL = COS_TABLE_BITS_DEF;
    localparam int PIPE_LATENCY = 8;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic signed [63:0] ONE_Q24 = 64'sd1 <<< 24;

    typedef struct {
        logic signed [28:0] pos_rate;
        logic signed [47:0] vel_rate;
        logic [30:0]        phase_rate;
        logic               capture;
    } deriv_t;

    typedef struct {
        logic [31:0] pos;
        logic [31:0] vel;
        logic [31:0] sim_time;
        logic [31:0] drive;
        logic        hit;
        bit          typed;
        deriv_t      want;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_addr = '0;
    logic [31:0] i_cfg_wdata = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [31:0] i_pos = '0;
    logic signed [31:0] i_vel = '0;
    logic [31:0] i_sim_time = '0;
    logic signed [31:0] i_drive = '0;
    logic i_hit = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [28:0] o_pos_rate;
    logic signed [47:0] o_vel_rate;
    logic [30:0] o_phase_rate;
    logic o_capture;

    duffing_quartic_derivative u_dut (.*);

    // shadow copy of the registers
    logic signed [31:0] damping_q = '0;
    logic signed [31:0] amp_q = '0;
    logic [30:0]        omega_q = '0;
    logic [31:0]        acq_start_q = ACQ_START_RST;

    deriv_t pending_derivs[$];
    longint cycle_cnt = 0;
    int     fail_cnt = 0;
    int     items_sent = 0;
    int     settings_used = 1;
    bit     calm = 1'b0;
    bit     hold_req = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [63:0] clamp_abs(input logic signed [63:0] v,
                                                    input logic signed [63:0] lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Taylor cosine of m/2^TBL turns for m in the first quarter, Q2.30
    function automatic logic signed [63:0] quarter_cos(input logic [63:0] m);
        logic [63:0] ang;
        logic [63:0] ang2;
        logic [63:0] term;
        logic signed [63:0] sum;
        ang = (m * TWO_PI_Q32 + (64'd1 << (TBL + 1))) >> (TBL + 2);
        ang2 = (ang * ang + (64'd1 << 29)) >> 30;
        term = 64'd1 << 30;
        sum = signed'(term);
        for (int k = 1; k <= 9; k++) begin
            term = ((term * ang2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) sum = sum - signed'(term);
            else sum = sum + signed'(term);
        end
        return sum;
    endfunction

    // cos(omega * t) in Q8.24 via phase in turns and a quadrant fold
    function automatic logic signed [63:0] forcing_cos(input logic [30:0] w,
                                                      input logic [31:0] t);
        logic [63:0] prod;
        logic [63:0] turns_c;
        logic [31:0] phase;
        logic [63:0] idx;
        logic [63:0] quad;
        logic [63:0] ofs;
        logic [63:0] quarter;
        logic signed [63:0] c;
        turns_c = 64'(INV_TWO_PI_Q32);
        prod = 64'(w) * 64'(t);
        phase = 32'(((prod >> 32) * turns_c + (((prod & 64'hFFFF_FFFF) * turns_c) >> 32)) >> 8);
        idx = ((64'(phase) + (64'd1 << (31 - TBL))) >> (32 - TBL)) & ((64'd1 << TBL) - 1);
        quarter = 64'd1 << (TBL - 2);
        quad = idx >> (TBL - 2);
        ofs = idx & (quarter - 1);
        case (quad)
            64'd0: c = quarter_cos(ofs);
            64'd1: c = -quarter_cos(quarter - ofs);
            64'd2: c = -quarter_cos(ofs);
            default: c = quarter_cos(quarter - ofs);
        endcase
        return round_shift(c, 6);
    endfunction

    function automatic deriv_t predict_deriv(input logic [31:0] pos, input logic [31:0] vel,
                                             input logic [31:0] t, input logic [31:0] drv,
                                             input logic hit);
        logic signed [63:0] x;
        logic signed [63:0] v;
        logic signed [63:0] ax;
        logic signed [63:0] s;
        logic signed [63:0] quart;
        logic signed [63:0] b;
        logic signed [63:0] a;
        logic signed [63:0] acc;
        deriv_t r;
        x = clamp_abs(64'(signed'(pos)), 8 * ONE_Q24);
        v = clamp_abs(64'(signed'(vel)), 15 * ONE_Q24);
        b = 64'(damping_q);
        a = 64'(amp_q);
        ax = (x < 0) ? -x : x;
        if (ax <= 4 * ONE_Q24) begin
            s = (ax * ax + (64'sd1 <<< 23)) >>> 24;
            quart = (s * s + (64'sd1 <<< 23)) >>> 24;
        end else begin
            quart = 256 * ONE_Q24 + ((ax - 4 * ONE_Q24) <<< 8);
            if (x < 0) quart = -quart;
        end
        acc = x - quart - round_shift(b * v, 24)
            + round_shift(a * forcing_cos(omega_q, t), 24) + 64'(signed'(drv));
        r.pos_rate = v[28:0];
        r.vel_rate = acc[47:0];
        r.phase_rate = omega_q;
        r.capture = hit && (t >= acq_start_q);
        return r;
    endfunction

    // item sender: random gap (none when calm), then hold the item until accepted
    task automatic send_item(input logic [31:0] pos, input logic [31:0] vel,
                             input logic [31:0] t, input logic [31:0] drv, input logic hit,
                             input bit typed, input deriv_t want);
        int gap;
        bit stalled;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos <= pos;
        i_vel <= vel;
        i_sim_time <= t;
        i_drive <= drv;
        i_hit <= hit;
        do begin
            @(negedge i_clk);
            stalled = o_stall;
            @(posedge i_clk);
        end while (stalled);
        pending_derivs.push_back(typed ? want : predict_deriv(pos, vel, t, drv, hit));
        items_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_derivs.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic load_regs(input logic [31:0] b, input logic [31:0] a,
                             input logic [31:0] w, input logic [31:0] s);
        logic [31:0] vals[4];
        vals = '{b, a, w, s};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_addr <= 2'(i);
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        damping_q = b;
        amp_q = a;
        omega_q = w[30:0];
        acq_start_q = s;
        settings_used++;
    endtask

    // position or velocity biased toward the clamp and knee regions
    function automatic logic [31:0] pick_state();
        case ($urandom_range(0, 5))
            0: return 32'(signed'($urandom_range(0, 2 * 67108864)) - 67108864);
            1: return 32'(signed'($urandom_range(67108865, 134217728)));
            2: return -32'(signed'($urandom_range(67108865, 134217728)));
            3: return 32'(67108864 + signed'($urandom_range(0, 2)) - 1)
                      ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
            4: return 32'(signed'($urandom_range(0, 2 * 251658241)) - 251658241);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_items(input int n);
        deriv_t none;
        logic [31:0] drv;
        none = '{default: '0};
        for (int i = 0; i < n; i++) begin
            drv = $urandom_range(0, 1) ? $urandom : 32'(signed'($urandom_range(0, 1 << 26)) - (1 << 25));
            send_item(pick_state(), pick_state(), $urandom, drv, 1'($urandom), 1'b0, none);
        end
    endtask

    // receiver: random stall before each item (none when calm), or a long hold on request
    initial begin
        int n;
        bit got;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                n = 80;
                hold_req = 1'b0;
            end else begin
                n = calm ? 0 : $urandom_range(0, 6);
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do begin
                @(negedge i_clk);
                got = o_valid && !i_stall;
                @(posedge i_clk);
            end while (!got);
        end
    end

    // result checker, sampled mid-cycle ahead of the accepting edge
    always @(negedge i_clk) begin
        deriv_t w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_derivs.size() == 0) begin
                $error("result with no item outstanding");
                fail_cnt++;
            end else begin
                w = pending_derivs.pop_front();
                if (o_pos_rate !== w.pos_rate) begin
                    $error("pos_rate exp %0d got %0d", w.pos_rate, o_pos_rate);
                    fail_cnt++;
                end
                if (o_vel_rate !== w.vel_rate) begin
                    $error("vel_rate exp %0d got %0d", w.vel_rate, o_vel_rate);
                    fail_cnt++;
                end
                if (o_phase_rate !== w.phase_rate) begin
                    $error("phase_rate exp %0d got %0d", w.phase_rate, o_phase_rate);
                    fail_cnt++;
                end
                if (o_capture !== w.capture) begin
                    $error("capture exp %0d got %0d", w.capture, o_capture);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        dir_row_t dir_rows[];
        // registers at reset: no damping, no forcing, capture from 10.0 s
        dir_rows = '{
            '{32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, '{29'sd0, 48'sd0, 31'd0, 1'b0}},
            // both states clamped high, capture exactly at the start time
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd655360, 32'h0, 1'b1, 1'b1,
              '{29'sd251658240, -48'sd21340618752, 31'd0, 1'b1}},
            // both states clamped low, one tick before the start time
            '{32'h8000_0000, 32'h8000_0000, 32'd655359, 32'h0, 1'b1, 1'b1,
              '{-29'sd251658240, 48'sd21340618752, 31'd0, 1'b0}},
            // at the knee, largest drive
            '{32'h0400_0000, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b0, 1'b1,
              '{29'sd0, -48'sd2080374785, 31'd0, 1'b0}},
            // negative knee, smallest drive, latest time
            '{32'hFC00_0000, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 1'b1,
              '{29'sd0, -48'sd6509559808, 31'd0, 1'b1}},
            // just past the knee: linear continuation
            '{32'h0400_0001, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1,
              '{29'sd0, -48'sd4227858687, 31'd0, 1'b0}},
            // x = 1 cancels; velocity exactly at and just past the clamp
            '{32'h0100_0000, 32'h0F00_0000, 32'h0, 32'h0, 1'b0, 1'b1,
              '{29'sd251658240, 48'sd0, 31'd0, 1'b0}},
            '{32'h0100_0000, 32'h0F00_0001, 32'h0, 32'h0, 1'b0, 1'b1,
              '{29'sd251658240, 48'sd0, 31'd0, 1'b0}},
            '{32'hFBFF_FFFF, 32'hF0FF_FFFF, 32'd1234567, 32'h0000_0001, 1'b1, 1'b0, '{default: '0}},
            '{32'h0800_0001, 32'h0EFF_FFFF, 32'd655361, 32'hFFFF_FFFF, 1'b1, 1'b0, '{default: '0}},
            '{32'hF7FF_FFFF, 32'h0000_0001, 32'd0, 32'h1234_5678, 1'b0, 1'b0, '{default: '0}},
            '{32'h0080_0000, 32'hFF80_0000, 32'd99999, 32'hC000_0000, 1'b1, 1'b0, '{default: '0}}
        };
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].pos, dir_rows[i].vel, dir_rows[i].sim_time, dir_rows[i].drive,
                      dir_rows[i].hit, dir_rows[i].typed, dir_rows[i].want);
        drain();

        // register extremes, then random settings
        load_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
        random_items(60);
        hold_req = 1'b1;
        random_items(90);
        drain();
        load_regs(32'h8000_0000, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
        random_items(150);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            calm = (ph == 1);
            load_regs($urandom, $urandom, $urandom, $urandom);
            random_items(75);
            drain();
            random_items(75);
            drain();
        end
        calm = 1'b0;
        load_regs(32'(signed'($urandom_range(0, 1 << 25)) - (1 << 24)), $urandom_range(0, 1 << 26),
                  $urandom_range(0, 1 << 28), 32'd655360);
        random_items(100);
        drain();

        $display("Covered %0d items across %0d register settings,", items_sent, settings_used);
        $display("with a long output hold and full-drain pauses between phases.");
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
